FILE: rtl/core/arpc_pkg.sv
package arpc_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;

	localparam int IP_W   = 32;
	localparam int MAC_W  = 48;
	localparam int STAT_W = 3;
	localparam int SLOT_W = 4;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	localparam logic [STAT_W-1:0] ST_MISS     = 3'd0;
	localparam logic [STAT_W-1:0] ST_HIT      = 3'd1;
	localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd2;
	localparam logic [STAT_W-1:0] ST_FILLED   = 3'd3;
	localparam logic [STAT_W-1:0] ST_REPLACED = 3'd4;

	typedef struct packed {
		logic             opcode;
		logic [IP_W-1:0]  ip_addr;
		logic [MAC_W-1:0] mac_in;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [MAC_W-1:0]  mac_out;
		logic [SLOT_W-1:0] slot;
	} rsp_t;

	typedef struct packed {
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
	} entry_t;

endpackage

FILE: rtl/core/arpc_mem.sv
module arpc_mem import arpc_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data
);

	entry_t mem_q [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: rtl/core/arpc_ctrl.sv
module arpc_ctrl import arpc_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	localparam int IDX_W = $clog2(TABLE_ENTRIES),
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             res_valid,
	input  logic             res_take,
	output rsp_t             res,
	output logic             wr_en,
	output logic [IDX_W-1:0] wr_addr,
	output entry_t           wr_data,
	output logic [IDX_W-1:0] rd_addr,
	input  entry_t           rd_data
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic             op_q;
	logic [IP_W-1:0]  ip_q;
	logic [MAC_W-1:0] mac_q;
	logic [IDX_W-1:0] cmp_idx_q;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [MAC_W-1:0] hit_mac_q;

	logic accept;
	logic match;
	logic last;
	logic full;

	assign accept    = (state_q == S_IDLE) && req_valid;
	assign req_stall = (state_q != S_IDLE);
	assign match     = (rd_data.ip == ip_q);
	assign last      = (cmp_idx_q == IDX_W'(count_q - CNT_W'(1)));
	assign full      = (count_q == CNT_W'(TABLE_ENTRIES));
	assign res_valid = (state_q == S_DONE);

	// Entries 0 to count-1 are the valid ones, so the scan reads them in order.
	assign rd_addr = (state_q == S_IDLE) ? '0 : cmp_idx_q + IDX_W'(1);

	always_comb begin
		res     = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '{ip: ip_q, mac: mac_q};
		if (op_q == OP_LOOKUP) begin
			if (hit_q) begin
				res.status  = ST_HIT;
				res.mac_out = hit_mac_q;
				res.slot    = SLOT_W'(hit_idx_q);
			end else begin
				res.status = ST_MISS;
			end
		end else begin
			wr_en = res_take;
			if (hit_q) begin
				res.status = ST_UPDATED;
				res.slot   = SLOT_W'(hit_idx_q);
				wr_addr    = hit_idx_q;
			end else if (!full) begin
				res.status = ST_FILLED;
				res.slot   = SLOT_W'(count_q);
				wr_addr    = IDX_W'(count_q);
			end else begin
				res.status = ST_REPLACED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (count_q == '0) ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (match || last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
						if (op_q == OP_INSERT && !hit_q && !full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= req.opcode;
			ip_q      <= req.ip_addr;
			mac_q     <= req.mac_in;
			cmp_idx_q <= '0;
			hit_q     <= 1'b0;
		end else if (state_q == S_SCAN) begin
			if (match) begin
				hit_q     <= 1'b1;
				hit_idx_q <= cmp_idx_q;
				hit_mac_q <= rd_data.mac;
			end else if (!last) begin
				cmp_idx_q <= cmp_idx_q + IDX_W'(1);
			end
		end
	end

endmodule

FILE: rtl/core/arp_address_cache.sv
// Channel  Direction  Payload  Handshake
// req      in         req_t    req_valid / req_stall
// rsp      out        rsp_t    rsp_valid / rsp_stall
//
// Each transaction is accepted, scans the valid entries in order through the
// single read port of the entry memory until a match, then delivers the result
// and, on an insert, writes back. Reset clears the fill count, the state and
// the output valid; entry memory needs no clearing pass. A result waits in the
// output register while rsp_stall is high, and the next transaction is scanned behind it.
module arp_address_cache import arpc_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic             res_valid;
	logic             res_take;
	rsp_t             res;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_data;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	arpc_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	arpc_mem #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign res_take  = res_valid && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

endmodule
